/* rtl/core/fpws_pkg.sv */
// ----------------------------------------------------------------------------
// fpws_pkg
// Shared widths, request codes, period table and divider handshake types for
// the frame pacer.
// ----------------------------------------------------------------------------
package fpws_pkg;

    // Field widths
    localparam int STAMP_W   = 31;
    localparam int REQ_W     = 2;
    localparam int RATE_W    = 8;
    localparam int WAIT_W    = 10;
    localparam int PERIOD_W  = 10;
    localparam int EST_W     = 16;

    // Estimate numerator: 1000 ms * 256 (UQ8.8) * (2*rate - 1) fits in 25 bits
    localparam int NUM_W     = 25;
    localparam int ODD_W     = 7;
    localparam int DIV_CNT_W = 5;

    localparam logic [RATE_W-1:0] RATE_RESET = 8'd60;
    localparam logic [RATE_W-1:0] MAX_RATE   = 8'd60;
    localparam logic [WAIT_W-1:0] MAX_WAIT   = 10'd1000;
    localparam logic [NUM_W-1:0]  NUM_SCALE  = 25'd256000;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PACE      = 2'd0,
        REQ_WAIT_DONE = 2'd1,
        REQ_DRAW      = 2'd2,
        REQ_NOP       = 2'd3
    } req_code_t;

    // floor(1000 / rate) for rate 1..60, zero elsewhere
    localparam logic [PERIOD_W-1:0] PERIOD_TBL [0:63] = '{
        10'd0,    10'd1000, 10'd500,  10'd333,  10'd250,  10'd200,  10'd166,  10'd142,
        10'd125,  10'd111,  10'd100,  10'd90,   10'd83,   10'd76,   10'd71,   10'd66,
        10'd62,   10'd58,   10'd55,   10'd52,   10'd50,   10'd47,   10'd45,   10'd43,
        10'd41,   10'd40,   10'd38,   10'd37,   10'd35,   10'd34,   10'd33,   10'd32,
        10'd31,   10'd30,   10'd29,   10'd28,   10'd27,   10'd27,   10'd26,   10'd25,
        10'd25,   10'd24,   10'd23,   10'd23,   10'd22,   10'd22,   10'd21,   10'd21,
        10'd20,   10'd20,   10'd20,   10'd19,   10'd19,   10'd18,   10'd18,   10'd18,
        10'd17,   10'd17,   10'd17,   10'd16,   10'd16,   10'd0,    10'd0,    10'd0
    };

    function automatic logic [PERIOD_W-1:0] period_of(input logic [RATE_W-1:0] rate);
        logic [PERIOD_W-1:0] p;
        p = '0;
        if (rate <= MAX_RATE) begin
            p = PERIOD_TBL[rate[5:0]];
        end
        return p;
    endfunction

    // Divider handshake
    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   numer;
        logic [STAMP_W-1:0] denom;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/fpws_if.sv */
// ----------------------------------------------------------------------------
// fpws_if
// Valid/ready channels of the frame pacer: request channel and result channel.
// ----------------------------------------------------------------------------
interface fpws_req_if import fpws_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [STAMP_W-1:0] now_ms;

    modport source (output valid, output req_type, output now_ms, input ready);
    modport sink   (input valid, input req_type, input now_ms, output ready);
endinterface

interface fpws_res_if import fpws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WAIT_W-1:0] wait_ms;
    logic              proceed_wait;
    logic              skip_draw;
    logic [EST_W-1:0]  rate_estimate;
    logic              rate_valid;

    modport source (output valid, output wait_ms, output proceed_wait, output skip_draw,
                    output rate_estimate, output rate_valid, input ready);
    modport sink   (input valid, input wait_ms, input proceed_wait, input skip_draw,
                    input rate_estimate, input rate_valid, output ready);
endinterface

/* rtl/core/frame_pacer_with_skip_core.sv */
// ----------------------------------------------------------------------------
// frame_pacer_with_skip_core
// Frame-rate limiter with frame skipping and a measured frame-rate estimate.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake        Payload
//  pace_in    in   valid/ready      req_type, now_ms
//  pace_out   out  valid/ready      wait_ms, proceed_wait, skip_draw,
//                                   rate_estimate, rate_valid
//  cfg        in   cfg_we (no wait) cfg_data -> target rate
//
//  One request at a time. The sequencer runs the ring update, the span read and
//  the 25-step serial divider when an estimate is possible, skips the divider
//  when it is not, and goes straight to the result when the target rate is
//  out of range.
//  The next request is taken while the previous result waits in the output
//  register; a stalled output holds the sequencer in its final step.
//  Reset (rst_n, asynchronous) empties the timestamp ring and clears the skip
//  flag; ring entries feed the estimate only after they are written.
//
module frame_pacer_with_skip_core import fpws_pkg::*;
#(
    parameter int RING_DEPTH = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [RATE_W-1:0] cfg_data,
    fpws_req_if.sink          pace_in,
    fpws_res_if.source        pace_out
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(RING_DEPTH);
    localparam logic [ADDR_W:0]   DEPTH_A = (ADDR_W + 1)'(RING_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOG,
        ST_SPAN_RD,
        ST_SPAN_CALC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [RATE_W-1:0]   target_rate_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                skip_pending_reg;
    logic [STAMP_W-1:0]  newest_reg;
    logic [STAMP_W-1:0]  d_reg;
    logic [STAMP_W-1:0]  log_data_reg;
    logic [STAMP_W-1:0]  span_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [STAMP_W-1:0]  rd_data_reg;

    logic [WAIT_W-1:0]   res_wait_reg;
    logic                res_proceed_reg;
    logic                res_skip_reg;
    logic [EST_W-1:0]    res_est_reg;
    logic                res_valid_reg;

    logic                out_valid_reg;
    logic [WAIT_W-1:0]   out_wait_reg;
    logic                out_proceed_reg;
    logic                out_skip_reg;
    logic [EST_W-1:0]    out_est_reg;
    logic                out_rvalid_reg;

    logic [STAMP_W-1:0]  ring_mem [RING_DEPTH];

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic                rate_ok;
    logic [PERIOD_W-1:0] period;
    logic [RATE_W:0]     rate_dbl;
    logic [CNT_W-1:0]    cap;
    logic [SUM_W-1:0]    wr_sum;
    logic [ADDR_W-1:0]   wr_idx;
    logic [ADDR_W:0]     head_sum;
    logic [ADDR_W-1:0]   head_inc;
    logic [CNT_W:0]      count_grow;
    logic                ring_over;
    logic [STAMP_W+1:0]  w_ext;
    logic [WAIT_W-1:0]   w_sat;
    logic                skip_ok;
    logic [ODD_W-1:0]    rate_odd;
    logic                est_ok;
    logic                mem_we;

    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic [EST_W-1:0]    div_quo;

    // Handshakes
    assign in_acc        = pace_in.valid && pace_in.ready;
    assign pace_in.ready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || pace_out.ready;
    assign out_load      = (state_reg == ST_FINISH) && out_free;

    // Rate decode, frame period and ring capacity
    always_comb
    begin
        rate_ok  = (target_rate_reg != '0) && (target_rate_reg <= MAX_RATE);
        period   = period_of(target_rate_reg);
        rate_dbl = {target_rate_reg, 1'b0};
        if (32'(rate_dbl) > 32'(RING_DEPTH))
        begin
            cap = CNT_W'(RING_DEPTH);
        end
        else
        begin
            cap = CNT_W'(rate_dbl);
        end
        rate_odd = {target_rate_reg[5:0], 1'b0} - ODD_W'(1);
    end

    // Ring addressing: write slot after the newest, wrap of the oldest
    always_comb
    begin
        wr_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (wr_sum >= DEPTH_S)
        begin
            wr_sum = wr_sum - DEPTH_S;
        end
        wr_idx   = wr_sum[ADDR_W-1:0];
        head_sum = {1'b0, head_reg} + 1'b1;
        if (head_sum == DEPTH_A)
        begin
            head_sum = '0;
        end
        head_inc   = head_sum[ADDR_W-1:0];
        count_grow = {1'b0, count_reg} + 1'b1;
        ring_over  = (count_grow > {1'b0, cap});
    end

    // Pace decision: w = period - took, took the signed elapsed time
    always_comb
    begin
        w_ext = {{(STAMP_W + 2 - PERIOD_W){1'b0}}, period}
              - {{2{d_reg[STAMP_W-1]}}, d_reg};
        if (w_ext[STAMP_W:0] > (STAMP_W + 1)'(MAX_WAIT))
        begin
            w_sat = MAX_WAIT;
        end
        else
        begin
            w_sat = w_ext[WAIT_W-1:0];
        end
        skip_ok = (d_reg < STAMP_W'({period, 1'b0}));
        est_ok  = (count_reg >= CNT_W'(2)) && (span_reg != '0);
    end

    // Target rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_rate_reg <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            target_rate_reg <= cfg_data;
        end
    end

    // Timestamp ring: one write port, one registered read of the oldest entry
    assign mem_we = (state_reg == ST_LOG);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_idx] <= log_data_reg;
        end
        rd_data_reg <= ring_mem[head_reg];
    end

    // Sequencer, ring pointers and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            skip_pending_reg <= 1'b0;
            newest_reg       <= '0;
            d_reg            <= '0;
            log_data_reg     <= '0;
            span_reg         <= '0;
            num_reg          <= '0;
            res_wait_reg     <= '0;
            res_proceed_reg  <= 1'b0;
            res_skip_reg     <= 1'b0;
            res_est_reg      <= '0;
            res_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_wait_reg     <= '0;
            out_proceed_reg  <= 1'b0;
            out_skip_reg     <= 1'b0;
            out_est_reg      <= '0;
            out_rvalid_reg   <= 1'b0;
        end
        else
        begin
            // Drop the result once the transaction completes
            if (pace_out.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        d_reg           <= pace_in.now_ms - newest_reg;
                        log_data_reg    <= pace_in.now_ms;
                        res_wait_reg    <= '0;
                        res_proceed_reg <= 1'b0;
                        res_skip_reg    <= 1'b0;
                        res_est_reg     <= '0;
                        res_valid_reg   <= 1'b0;
                        if (!rate_ok)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            unique case (req_code_t'(pace_in.req_type))
                                REQ_PACE:
                                begin
                                    res_proceed_reg <= 1'b1;
                                    state_reg <= (count_reg == '0) ? ST_SPAN_RD : ST_DECIDE;
                                end
                                REQ_WAIT_DONE:
                                begin
                                    state_reg <= ST_LOG;
                                end
                                REQ_DRAW:
                                begin
                                    res_skip_reg     <= skip_pending_reg;
                                    skip_pending_reg <= 1'b0;
                                    state_reg        <= ST_SPAN_RD;
                                end
                                default:
                                begin
                                    state_reg <= ST_SPAN_RD;
                                end
                            endcase
                        end
                    end
                end

                ST_DECIDE:
                begin
                    if (!w_ext[STAMP_W+1])
                    begin
                        res_wait_reg <= w_sat;
                        state_reg    <= ST_SPAN_RD;
                    end
                    else if (skip_ok)
                    begin
                        // Late by less than one period: log the ideal stamp
                        log_data_reg     <= newest_reg + STAMP_W'(period);
                        skip_pending_reg <= 1'b1;
                        res_proceed_reg  <= 1'b0;
                        state_reg        <= ST_LOG;
                    end
                    else
                    begin
                        state_reg <= ST_SPAN_RD;
                    end
                end

                ST_LOG:
                begin
                    newest_reg <= log_data_reg;
                    if (ring_over)
                    begin
                        head_reg <= head_inc;
                    end
                    else
                    begin
                        count_reg <= count_grow[CNT_W-1:0];
                    end
                    state_reg <= ST_SPAN_RD;
                end

                ST_SPAN_RD:
                begin
                    state_reg <= ST_SPAN_CALC;
                end

                ST_SPAN_CALC:
                begin
                    span_reg  <= newest_reg - rd_data_reg;
                    num_reg   <= NUM_W'(NUM_SCALE * NUM_W'(rate_odd));
                    state_reg <= ST_DIV_GO;
                end

                ST_DIV_GO:
                begin
                    state_reg <= est_ok ? ST_DIV_WAIT : ST_FINISH;
                end

                ST_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        res_est_reg   <= div_quo;
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_wait_reg    <= res_wait_reg;
                        out_proceed_reg <= res_proceed_reg;
                        out_skip_reg    <= res_skip_reg;
                        out_est_reg     <= res_est_reg;
                        out_rvalid_reg  <= res_valid_reg;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Serial divider for the rate estimate
    assign div_ctrl.start = (state_reg == ST_DIV_GO) && est_ok;
    assign div_ctrl.numer = num_reg;
    assign div_ctrl.denom = span_reg;

    fpws_sdiv u_sdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (div_ctrl),
        .stat    (div_stat),
        .quo_sat (div_quo)
    );

    // Result channel
    assign pace_out.valid         = out_valid_reg;
    assign pace_out.wait_ms       = out_wait_reg;
    assign pace_out.proceed_wait  = out_proceed_reg;
    assign pace_out.skip_draw     = out_skip_reg;
    assign pace_out.rate_estimate = out_est_reg;
    assign pace_out.rate_valid    = out_rvalid_reg;

    // Assertions
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_log_fills_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOG) |=> (count_reg != '0))
        else $error("ring empty after a logged stamp");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> (!div_stat.busy && span_reg != '0))
        else $error("divider started while busy or with zero span");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into output register");

endmodule

/* rtl/core/fpws_sdiv.sv */
// ----------------------------------------------------------------------------
// fpws_sdiv
// Radix-2 restoring divider: one quotient bit per cycle, result saturated
// to 16 bits.
// ----------------------------------------------------------------------------
module fpws_sdiv import fpws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    output div_stat_t        stat,
    output logic [EST_W-1:0] quo_sat
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [STAMP_W-1:0]   rem_reg;
    logic [STAMP_W-1:0]   den_reg;
    logic [NUM_W-1:0]     quo_reg;

    logic [STAMP_W:0]     trial;
    logic                 fits;

    // Shift in the next numerator bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Iterate one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W);
                rem_reg  <= '0;
                den_reg  <= ctrl.denom;
                quo_reg  <= ctrl.numer;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= STAMP_W'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= trial[STAMP_W-1:0];
                end
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Saturate the quotient to UQ8.8 range
    assign quo_sat   = (|quo_reg[NUM_W-1:EST_W]) ? {EST_W{1'b1}} : quo_reg[EST_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* tb/tb_frame_pacer_with_skip_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_pacer_with_skip_core
// Self-checking bench for the frame pacer. A driver process feeds pace
// checks, wait-finished and draw requests from a backlog. A scoreboard
// predicts each reply: wait time, drop decision, skip flag and the UQ8.8
// frame-rate estimate. A monitor process compares every reply field by field.
// Target rates cover the valid extremes, the out-of-range codes and settings
// in between. Request gaps and output backpressure are random, with one long
// output stall.
// ----------------------------------------------------------------------------
module tb_frame_pacer_with_skip_core;
    import fpws_pkg::*;

    localparam int     RING_SLOTS    = 128;
    localparam longint EST_SCALE     = 1000 * 256;
    localparam int     LATENCY_PAD   = 40;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     STALL_LIMIT   = 4000;
    localparam int     TAIL_CYCLES   = 60;
    localparam int     MODE_A_ITEMS  = 570;
    localparam int     MODE_B_ITEMS  = 1140;

    typedef struct packed {
        req_code_t          kind;
        logic [STAMP_W-1:0] now_ms;
    } pace_req_t;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_ms;
        logic              proceed_wait;
        logic              skip_draw;
        logic [EST_W-1:0]  rate_estimate;
        logic              rate_valid;
    } pace_res_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [RATE_W-1:0] cfg_data;

    fpws_req_if req_bus ();
    fpws_res_if res_bus ();

    frame_pacer_with_skip_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .pace_in  (req_bus),
        .pace_out (res_bus)
    );

    // Scoreboard copy of the pacer state
    logic [STAMP_W-1:0] stamp_ring [0:RING_SLOTS-1];
    int                 ring_head   = 0;
    int                 ring_count  = 0;
    logic               skip_flag   = 1'b0;
    logic [RATE_W-1:0]  tgt_rate    = RATE_RESET;

    pace_req_t          req_backlog [$];
    pace_res_t          expected_replies [$];

    int                 items_sent   = 0;
    int                 results_seen = 0;
    int                 mismatches   = 0;
    int                 drops_seen   = 0;
    int                 quiet_cycles = 0;
    int                 hold_ticket  = 0;
    int                 hold_served  = 0;
    int                 hold_left    = 0;
    logic [STAMP_W-1:0] t_ms         = '0;

    // ------------------------------------------------------------------
    // Reply prediction
    // ------------------------------------------------------------------
    function automatic logic [STAMP_W-1:0] newest_stamp();
        return stamp_ring[(ring_head + ring_count - 1) % RING_SLOTS];
    endfunction

    function automatic void log_stamp(input logic [STAMP_W-1:0] stamp);
        int cap;
        cap = (2 * int'(tgt_rate) > RING_SLOTS) ? RING_SLOTS : 2 * int'(tgt_rate);
        stamp_ring[(ring_head + ring_count) % RING_SLOTS] = stamp;
        ring_count++;
        // Retire the oldest stamp once the ring is over capacity
        if (ring_count > cap) begin
            ring_head = (ring_head + 1) % RING_SLOTS;
            ring_count--;
        end
    endfunction

    function automatic pace_res_t advance_pacer(input req_code_t kind,
                                                input logic [STAMP_W-1:0] now);
        pace_res_t          r;
        logic [STAMP_W-1:0] last;
        logic [STAMP_W-1:0] diff;
        logic [STAMP_W-1:0] span;
        longint             period;
        longint             took;
        longint             slack;
        longint             quo;
        r = '0;
        if (tgt_rate >= 1 && tgt_rate <= MAX_RATE) begin
            period = 1000 / int'(tgt_rate);
            case (kind)
                REQ_PACE: begin
                    r.proceed_wait = 1'b1;
                    if (ring_count != 0) begin
                        last = newest_stamp();
                        diff = now - last;
                        took = longint'(diff);
                        if (diff[STAMP_W-1])
                            took = took - 64'sd2147483648;
                        slack = period - took;
                        if (slack >= 0) begin
                            r.wait_ms = (slack > 1000) ? MAX_WAIT : slack[WAIT_W-1:0];
                        end
                        else if (-slack < period) begin
                            // Late by less than a frame: drop it, log the ideal stamp
                            log_stamp(last + STAMP_W'(period));
                            skip_flag      = 1'b1;
                            r.proceed_wait = 1'b0;
                            drops_seen++;
                        end
                    end
                end
                REQ_WAIT_DONE: begin
                    log_stamp(now);
                end
                REQ_DRAW: begin
                    r.skip_draw = skip_flag;
                    skip_flag   = 1'b0;
                end
                default: begin
                end
            endcase
            // Estimate from the ring as it stands after the request
            if (ring_count >= 2) begin
                span = newest_stamp() - stamp_ring[ring_head];
                if (span != 0) begin
                    quo = (EST_SCALE * (2 * longint'(tgt_rate) - 1)) / longint'(span);
                    r.rate_estimate = (quo > 65535) ? 16'hFFFF : quo[EST_W-1:0];
                    r.rate_valid    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle percentages by traffic stage
    // ------------------------------------------------------------------
    function automatic int tx_idle_pct();
        if (items_sent < MODE_A_ITEMS)
            return 34;
        else if (items_sent < MODE_B_ITEMS)
            return 88;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (items_sent < MODE_A_ITEMS)
            return 88;
        else if (items_sent < MODE_B_ITEMS)
            return 34;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_PACE;
        req_bus.now_ms   = '0;
        res_bus.ready    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver: predict on each accepted transaction, then advance
    // ------------------------------------------------------------------
    always @(posedge clk) begin : req_driver
        pace_req_t nxt;
        pace_res_t pred;
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
        end
        else begin
            if (req_bus.valid && req_bus.ready) begin
                pred = advance_pacer(req_code_t'(req_bus.req_type), req_bus.now_ms);
                expected_replies = {expected_replies, pred};
                items_sent <= items_sent + 1;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
                    nxt = req_backlog[0];
                    req_backlog.delete(0);
                    req_bus.valid    <= 1'b1;
                    req_bus.req_type <= nxt.kind;
                    req_bus.now_ms   <= nxt.now_ms;
                end
                else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, plus a long hold when requested
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
        end
        else if (hold_left != 0) begin
            res_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_served != hold_ticket) begin
            hold_served   <= hold_ticket;
            hold_left     <= HOLD_CYCLES;
            res_bus.ready <= 1'b0;
        end
        else begin
            res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : res_monitor
        pace_res_t want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            results_seen <= results_seen + 1;
            if (expected_replies.size() == 0) begin
                $error("result transaction with no request outstanding");
                mismatches++;
            end
            else begin
                want = expected_replies[0];
                expected_replies.delete(0);
                check_field("wait_ms", want.wait_ms, res_bus.wait_ms);
                check_field("proceed_wait", want.proceed_wait, res_bus.proceed_wait);
                check_field("skip_draw", want.skip_draw, res_bus.skip_draw);
                check_field("rate_estimate", want.rate_estimate, res_bus.rate_estimate);
                check_field("rate_valid", want.rate_valid, res_bus.rate_valid);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_req(input req_code_t kind, input logic [STAMP_W-1:0] now);
        pace_req_t item;
        item.kind   = kind;
        item.now_ms = now;
        req_backlog = {req_backlog, item};
    endtask

    // Hold off until every request is answered
    task automatic drain_pacer();
        while (req_backlog.size() != 0 || req_bus.valid || expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        drain_pacer();
        repeat (LATENCY_PAD) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= rate;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tgt_rate  = rate;
    endtask

    // Frame loops with random timing, bursts of close stamps and raw noise
    task automatic gen_traffic(input int n);
        int                 added;
        int                 per;
        int                 pick;
        int                 k;
        logic [STAMP_W-1:0] pace_t;
        added = 0;
        per   = (tgt_rate >= 1 && tgt_rate <= MAX_RATE) ? 1000 / int'(tgt_rate) : 16;
        while (added < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                push_req(req_code_t'($urandom_range(0, 3)), STAMP_W'($urandom));
                added++;
            end
            else if (pick < 16) begin
                for (k = 0; k < 8; k++) begin
                    t_ms = t_ms + STAMP_W'($urandom_range(0, 2));
                    push_req(REQ_WAIT_DONE, t_ms);
                end
                added += 8;
            end
            else begin
                pace_t = t_ms + STAMP_W'($urandom_range(0, 3 * per));
                push_req(REQ_PACE, pace_t);
                t_ms = pace_t;
                added++;
                if ($urandom_range(0, 3) != 0) begin
                    t_ms = t_ms + STAMP_W'($urandom_range(0, per));
                    push_req(REQ_WAIT_DONE, t_ms);
                    added++;
                end
                if ($urandom_range(0, 1) != 0) begin
                    push_req(REQ_DRAW, t_ms);
                    added++;
                end
            end
        end
    endtask

    initial begin
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed cases at the reset rate of 60 (period 16)
        push_req(REQ_PACE, 31'd0);              // empty ring
        push_req(REQ_DRAW, 31'd0);
        push_req(REQ_NOP, 31'h7FFF_FFFF);
        push_req(REQ_WAIT_DONE, 31'd100);
        push_req(REQ_WAIT_DONE, 31'd100);       // zero span
        push_req(REQ_PACE, 31'd105);            // early
        push_req(REQ_PACE, 31'd121);            // late by less than a frame
        push_req(REQ_DRAW, 31'd121);
        push_req(REQ_DRAW, 31'd121);
        push_req(REQ_PACE, 31'd172);            // very late
        push_req(REQ_PACE, 31'd50);             // clock behind the last stamp
        push_req(REQ_PACE, 31'd132);            // exactly on time
        push_req(REQ_PACE, 31'd148);            // late by exactly one frame
        push_req(REQ_WAIT_DONE, 31'h7FFF_FFF0);
        push_req(REQ_PACE, 31'd5);              // late across the wrap
        push_req(REQ_WAIT_DONE, 31'h7FFF_FFFF);
        push_req(REQ_WAIT_DONE, 31'd0);
        push_req(REQ_DRAW, 31'd0);

        // Slowest valid rate: saturated wait and sign of the elapsed time
        write_rate(8'd1);
        push_req(REQ_WAIT_DONE, 31'd1000);
        push_req(REQ_PACE, 31'd990);
        push_req(REQ_PACE, 31'd2999);
        push_req(REQ_PACE, 31'd1000 + 31'h4000_0000);
        push_req(REQ_PACE, 31'd999 + 31'h4000_0000);
        t_ms = 31'd5000;
        gen_traffic(140);

        write_rate(8'd0);
        gen_traffic(30);

        // Cross the millisecond counter wrap at the fastest rate
        write_rate(8'd60);
        t_ms = 31'h7FFF_E000;
        gen_traffic(420);

        write_rate(8'd255);
        gen_traffic(30);

        // Long output stall while requests keep coming
        write_rate(8'd37);
        hold_ticket++;
        gen_traffic(350);

        write_rate(8'd61);
        gen_traffic(30);

        write_rate(8'd2);
        gen_traffic(200);

        write_rate(8'd60);
        gen_traffic(500);

        drain_pacer();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_replies.size() != 0) begin
            $error("%0d expected results never arrived", expected_replies.size());
            mismatches++;
        end

        $display("Run covered %0d requests and %0d replies over target rates", items_sent,
                 results_seen);
        $display("60, 1, 0, 60, 255, 37, 61, 2, 60 with %0d predicted frame drops", drops_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
